[rtl/cle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// Shared constants, codes and types of the circular list engine.
// ----------------------------------------------------------------------------
package cle_pkg;

	localparam int CAPACITY = 16;
	localparam int PTR_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;

	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_DELETE = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_EMPTY     = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APP_NODE,
		ST_APP_LINK,
		ST_DEL_RD,
		ST_DEL_CHK,
		ST_RD_RD,
		ST_RD_OUT,
		ST_EMIT
	} cle_state_t;

	typedef struct packed {
		logic             value_we;
		logic             link_we;
		logic [PTR_W-1:0] addr;
		logic [VAL_W-1:0] value;
		logic [PTR_W-1:0] link;
	} node_wr_t;

endpackage

[rtl/cle_node_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_node_mem
// Node storage: value and link memories, one write port, one read port
// with registered read data.
// ----------------------------------------------------------------------------
module cle_node_mem (
	input  logic                          clk,
	input  cle_pkg::node_wr_t             wr,
	input  logic                          rd_en,
	input  logic [cle_pkg::PTR_W-1:0]     rd_addr,
	output logic [cle_pkg::VAL_W-1:0]     rd_value,
	output logic [cle_pkg::PTR_W-1:0]     rd_link
);
	import cle_pkg::*;

	logic [VAL_W-1:0] value_mem [CAPACITY];
	logic [PTR_W-1:0] link_mem  [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.value_we) begin
			value_mem[wr.addr] <= wr.value;
		end
		if (wr.link_we) begin
			link_mem[wr.addr] <= wr.link;
		end
	end

	// read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_value <= value_mem[rd_addr];
			rd_link  <= link_mem[rd_addr];
		end
	end

endmodule

[rtl/circular_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_list_engine
// Bounded circular singly linked list of signed 32-bit values.
// ----------------------------------------------------------------------------
// One request word is taken at a time; s_tready is high only while the engine
// is idle. An append writes the new node, then links the old tail (if any) to
// it, then posts its status. A delete issues a read of the head node, then
// checks one node per step through the link memory (up to the node count),
// then posts its status. A read issues a read of the head node and then gives
// one output word per stored node, in order from head to tail, with m_tlast on
// the final one. The pace of delete and read is set by the registered read
// data of the node memory: each step of the walk needs the link of the node
// before it. An empty list, a full list or a missing value gives a single
// status word. Request kind 3 is dropped without a result. Results wait in an
// output register, so a stalled m_tready only pauses the walk.
// ----------------------------------------------------------------------------
module circular_list_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] item_value
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] read_value
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast    // last_of_run
);
	import cle_pkg::*;

	cle_state_t state_q, state_nx;

	logic [PTR_W-1:0]    head_q, tail_q, cur_q, prev_q, slot_q;
	logic [CNT_W-1:0]    count_q, walk_q;
	logic [CAPACITY-1:0] free_q;
	logic [VAL_W-1:0]    val_q;
	logic [1:0]          stat_q;

	logic [PTR_W-1:0] free_slot;
	logic [VAL_W-1:0] rd_value;
	logic [PTR_W-1:0] rd_link;
	logic             rd_en;
	logic [PTR_W-1:0] rd_addr;
	node_wr_t         wr;

	logic             accept, can_emit, emit, emit_last, match, walk_end;
	logic [1:0]       emit_status;
	logic [VAL_W-1:0] emit_value;
	logic [CNT_W-1:0] walk_nx;
	logic             is_empty, is_full;

	assign accept   = s_tvalid && s_tready;
	assign can_emit = !m_tvalid || m_tready;
	assign match    = rd_value == val_q;
	assign walk_nx  = walk_q + CNT_W'(1);
	assign walk_end = walk_nx == count_q;
	assign is_empty = count_q == '0;
	assign is_full  = count_q == CNT_W'(CAPACITY);

	// lowest free slot
	always_comb begin
		free_slot = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_slot = PTR_W'(i);
			end
		end
	end

	cle_node_mem u_mem (
		.clk      (clk),
		.wr       (wr),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_value (rd_value),
		.rd_link  (rd_link)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					unique case (s_tuser)
						REQ_APPEND: state_nx = is_full  ? ST_EMIT : ST_APP_NODE;
						REQ_DELETE: state_nx = is_empty ? ST_EMIT : ST_DEL_RD;
						REQ_READ:   state_nx = is_empty ? ST_EMIT : ST_RD_RD;
						default:    state_nx = ST_IDLE;
					endcase
				end
			end
			ST_APP_NODE: state_nx = ST_APP_LINK;
			ST_APP_LINK: state_nx = ST_EMIT;
			ST_DEL_RD:   state_nx = ST_DEL_CHK;
			ST_DEL_CHK: begin
				if (match || walk_end) begin
					state_nx = ST_EMIT;
				end
			end
			ST_RD_RD: state_nx = ST_RD_OUT;
			ST_RD_OUT: begin
				if (can_emit && walk_end) begin
					state_nx = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (can_emit) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		s_tready    = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = cur_q;
		wr          = '0;
		emit        = 1'b0;
		emit_status = STAT_OK;
		emit_value  = '0;
		emit_last   = 1'b1;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_APP_NODE: begin
				wr.value_we = 1'b1;
				wr.link_we  = 1'b1;
				wr.addr     = slot_q;
				wr.value    = val_q;
				wr.link     = is_empty ? slot_q : head_q;
			end
			ST_APP_LINK: begin
				wr.link_we = !is_empty;
				wr.addr    = tail_q;
				wr.link    = slot_q;
			end
			ST_DEL_RD: begin
				rd_en   = 1'b1;
				rd_addr = cur_q;
			end
			ST_DEL_CHK: begin
				if (match) begin
					// unlink by pointing the predecessor past the match
					wr.link_we = !(cur_q == head_q && count_q == CNT_W'(1));
					wr.addr    = prev_q;
					wr.link    = rd_link;
				end else if (!walk_end) begin
					rd_en   = 1'b1;
					rd_addr = rd_link;
				end
			end
			ST_RD_RD: begin
				rd_en   = 1'b1;
				rd_addr = head_q;
			end
			ST_RD_OUT: begin
				if (can_emit) begin
					emit       = 1'b1;
					emit_value = rd_value;
					emit_last  = walk_end;
					rd_en      = !walk_end;
					rd_addr    = rd_link;
				end
			end
			ST_EMIT: begin
				if (can_emit) begin
					emit        = 1'b1;
					emit_status = stat_q;
				end
			end
			default: ;
		endcase
	end

	// list control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			free_q  <= '1;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_APP_LINK) begin
				if (is_empty) begin
					head_q <= slot_q;
				end
				tail_q         <= slot_q;
				free_q[slot_q] <= 1'b0;
				count_q        <= count_q + CNT_W'(1);
			end
			if (state_q == ST_DEL_CHK && match) begin
				if (cur_q == head_q) begin
					if (count_q == CNT_W'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end else begin
						head_q <= rd_link;
					end
				end else if (cur_q == tail_q) begin
					tail_q <= prev_q;
				end
				free_q[cur_q] <= 1'b1;
				count_q       <= count_q - CNT_W'(1);
			end
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q  <= s_tdata;
			slot_q <= free_slot;
			cur_q  <= head_q;
			prev_q <= tail_q;
			walk_q <= '0;
			priority if (s_tuser == REQ_APPEND && is_full) begin
				stat_q <= STAT_FULL;
			end else if (s_tuser != REQ_APPEND && is_empty) begin
				stat_q <= STAT_EMPTY;
			end else begin
				stat_q <= STAT_OK;
			end
		end
		if (state_q == ST_DEL_CHK) begin
			if (match) begin
				stat_q <= STAT_OK;
			end else if (walk_end) begin
				stat_q <= STAT_NOT_FOUND;
			end else begin
				prev_q <= cur_q;
				cur_q  <= rd_link;
				walk_q <= walk_nx;
			end
		end
		if (state_q == ST_RD_OUT && emit) begin
			walk_q <= walk_nx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata <= emit_value;
			m_tuser <= emit_status;
			m_tlast <= emit_last;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("node count above capacity");

	a_free_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(free_q) + int'(count_q) == CAPACITY)
		else $error("free map disagrees with node count");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		is_empty |-> (head_q == '0 && tail_q == '0))
		else $error("empty list with nonzero head or tail");

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!m_tvalid || m_tready))
		else $error("result word overwrites one not yet taken");

endmodule

[tb/tb_circular_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_list_engine
// Self-checking testbench for the circular list engine.
// ----------------------------------------------------------------------------
// Request words go in on the slave stream with random gaps. A local copy of
// the list (values, links, head, tail, count, free slots) is updated on each
// accepted request and queues the status and read words it should produce.
// Every output word is checked against the oldest queued word. Directed tests
// cover the empty, single-node, full and duplicate cases, then random traffic
// grows and shrinks the list, with back-pressure and sender pauses mixed in.
// ----------------------------------------------------------------------------
module tb_circular_list_engine;

	import cle_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int PRESSURE_HOLD = 300;

	typedef struct {
		logic [1:0]       status;
		logic [VAL_W-1:0] value;
		logic             last;
	} list_word_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [31:0]       s_tdata;
	logic [1:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [31:0]       m_tdata;
	logic [1:0]        m_tuser;
	logic              m_tlast;

	// local copy of the list
	logic [VAL_W-1:0]    node_val [CAPACITY];
	logic [PTR_W-1:0]    node_next [CAPACITY];
	logic [PTR_W-1:0]    head_slot;
	logic [PTR_W-1:0]    tail_slot;
	int                  node_count;
	logic [CAPACITY-1:0] free_slots;

	list_word_t expected_words [$];
	int         fail_count;
	int         cycle_count;
	int         rx_hold_request;
	int         rx_stall_left;
	bit         sender_steady;
	bit         rx_steady;

	circular_list_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	function automatic void push_word(logic [1:0] st, logic [VAL_W-1:0] v, logic lst);
		list_word_t w;
		w.status = st;
		w.value  = v;
		w.last   = lst;
		expected_words.push_back(w);
	endfunction

	function automatic void list_append(logic [VAL_W-1:0] v);
		int slot;
		slot = -1;
		if (node_count >= CAPACITY) begin
			push_word(STAT_FULL, '0, 1'b1);
			return;
		end
		for (int i = 0; i < CAPACITY; i++) begin
			if (free_slots[i]) begin
				slot = i;
				break;
			end
		end
		free_slots[slot] = 1'b0;
		node_val[slot] = v;
		if (node_count == 0) begin
			head_slot = PTR_W'(slot);
			tail_slot = PTR_W'(slot);
			node_next[slot] = PTR_W'(slot);
		end else begin
			node_next[tail_slot] = PTR_W'(slot);
			node_next[slot] = head_slot;
			tail_slot = PTR_W'(slot);
		end
		node_count++;
		push_word(STAT_OK, '0, 1'b1);
	endfunction

	function automatic void list_delete(logic [VAL_W-1:0] v);
		logic [PTR_W-1:0] prev;
		logic [PTR_W-1:0] cur;
		logic [PTR_W-1:0] nxt;
		if (node_count == 0) begin
			push_word(STAT_EMPTY, '0, 1'b1);
			return;
		end
		prev = tail_slot;
		cur = head_slot;
		for (int n = 0; n < node_count; n++) begin
			if (node_val[cur] == v) begin
				nxt = node_next[cur];
				if (cur == head_slot) begin
					if (node_count == 1) begin
						head_slot = '0;
						tail_slot = '0;
					end else begin
						node_next[prev] = nxt;
						head_slot = nxt;
					end
				end else if (cur == tail_slot) begin
					node_next[prev] = nxt;
					tail_slot = prev;
				end else begin
					node_next[prev] = nxt;
				end
				free_slots[cur] = 1'b1;
				node_count--;
				push_word(STAT_OK, '0, 1'b1);
				return;
			end
			prev = cur;
			cur = node_next[cur];
		end
		push_word(STAT_NOT_FOUND, '0, 1'b1);
	endfunction

	function automatic void list_read();
		logic [PTR_W-1:0] cur;
		if (node_count == 0) begin
			push_word(STAT_EMPTY, '0, 1'b1);
			return;
		end
		cur = head_slot;
		for (int n = 0; n < node_count; n++) begin
			push_word(STAT_OK, node_val[cur], n + 1 == node_count);
			cur = node_next[cur];
		end
	endfunction

	function automatic void predict_request(logic [1:0] kind, logic [VAL_W-1:0] v);
		case (kind)
			REQ_APPEND: list_append(v);
			REQ_DELETE: list_delete(v);
			REQ_READ:   list_read();
			default:    ;
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] value_at_position(int pos);
		logic [PTR_W-1:0] cur;
		cur = head_slot;
		for (int n = 0; n < pos; n++)
			cur = node_next[cur];
		return node_val[cur];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 25);
	endfunction

	// duplicates and extremes show up often
	function automatic logic [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return $urandom;
		else if (r < 8)
			return $signed($urandom_range(0, 8)) - 4;
		else if (r < 9)
			return 32'h8000_0000 + $urandom_range(0, 1);
		else
			return 32'h7fff_ffff - $urandom_range(0, 1);
	endfunction

	task automatic send_request(input logic [1:0] kind, input logic [VAL_W-1:0] v);
		int gap;
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= v;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_request(kind, v);
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	task automatic send_random_request(input bit grow);
		int r;
		int append_pct;
		r = $urandom_range(0, 99);
		append_pct = grow ? 55 : 25;
		if (r < 2)
			send_request(REQ_UNUSED, $urandom);
		else if (r < 2 + append_pct)
			send_request(REQ_APPEND, pick_value());
		else if (r < 87) begin
			if (node_count > 0 && $urandom_range(0, 9) < 8)
				send_request(REQ_DELETE,
					value_at_position($urandom_range(0, node_count - 1)));
			else
				send_request(REQ_DELETE, pick_value());
		end else
			send_request(REQ_READ, $urandom);
	endtask

	task automatic test_empty_list();
		send_request(REQ_READ, 32'h0);
		send_request(REQ_DELETE, 32'h0);
		send_request(REQ_UNUSED, 32'hffff_ffff);
		send_request(REQ_READ, 32'hffff_ffff);
	endtask

	task automatic test_append_extremes();
		send_request(REQ_APPEND, 32'h8000_0000);
		send_request(REQ_APPEND, 32'h7fff_ffff);
		send_request(REQ_APPEND, 32'h0);
		send_request(REQ_APPEND, 32'hffff_ffff);
		send_request(REQ_READ, 32'h0);
	endtask

	task automatic test_delete_cases();
		send_request(REQ_DELETE, 32'h0000_3039);   // no match
		send_request(REQ_DELETE, 32'h0);           // middle node
		send_request(REQ_DELETE, 32'h8000_0000);   // head
		send_request(REQ_DELETE, 32'hffff_ffff);   // tail
		send_request(REQ_READ, 32'h0);
		send_request(REQ_DELETE, 32'h7fff_ffff);   // only node left
		send_request(REQ_READ, 32'h0);
		// first of two equal values goes, freed slot is reused
		send_request(REQ_APPEND, 32'd7);
		send_request(REQ_APPEND, 32'd9);
		send_request(REQ_APPEND, 32'd7);
		send_request(REQ_DELETE, 32'd7);
		send_request(REQ_APPEND, 32'd5);
		send_request(REQ_READ, 32'h0);
	endtask

	task automatic test_full_list();
		while (node_count < CAPACITY)
			send_request(REQ_APPEND, pick_value());
		send_request(REQ_APPEND, 32'h1234_5678);
		send_request(REQ_READ, 32'h0);
		send_request(REQ_DELETE, value_at_position(CAPACITY - 1));
		send_request(REQ_APPEND, 32'h5555_aaaa);
		send_request(REQ_APPEND, 32'haaaa_5555);
		send_request(REQ_READ, 32'h0);
	endtask

	// receiver stops long enough for the output word to back up into the input
	task automatic test_backpressure();
		rx_hold_request = PRESSURE_HOLD;
		send_request(REQ_READ, 32'h0);
		send_request(REQ_APPEND, pick_value());
		send_request(REQ_READ, 32'h0);
		send_request(REQ_DELETE, value_at_position(0));
		send_request(REQ_READ, 32'h0);
	endtask

	task automatic test_steady_stream();
		sender_steady = 1'b1;
		rx_steady = 1'b1;
		for (int i = 0; i < 40; i++)
			send_random_request(i < 20);
		sender_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 8; phase++) begin
			for (int i = 0; i < 50; i++)
				send_random_request(phase % 2 == 0);
			if (phase == 3)
				wait_results_drained();
		end
	endtask

	// receiver side: random stalls plus one long requested hold
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_stall_left > 0) begin
				m_tready <= 1'b0;
				rx_stall_left--;
			end else if (rx_hold_request > 0) begin
				m_tready <= 1'b0;
				rx_stall_left = rx_hold_request - 1;
				rx_hold_request = 0;
			end else if (!rx_steady && $urandom_range(0, 99) < 15) begin
				m_tready <= 1'b0;
				if ($urandom_range(0, 9) < 8)
					rx_stall_left = $urandom_range(0, 2);
				else
					rx_stall_left = $urandom_range(7, 29);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		list_word_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				$error("unexpected word: status %0d, read_value %0d, last_of_run %0d",
					m_tuser, $signed(m_tdata), m_tlast);
				fail_count++;
			end else begin
				w = expected_words.pop_front();
				if (m_tuser !== w.status) begin
					$error("status: expected %0d, actual %0d", w.status, m_tuser);
					fail_count++;
				end
				if (m_tdata !== w.value) begin
					$error("read_value: expected %0d, actual %0d",
						$signed(w.value), $signed(m_tdata));
					fail_count++;
				end
				if (m_tlast !== w.last) begin
					$error("last_of_run: expected %0d, actual %0d", w.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		fail_count = 0;
		cycle_count = 0;
		rx_hold_request = 0;
		rx_stall_left = 0;
		sender_steady = 1'b0;
		rx_steady = 1'b0;
		head_slot = '0;
		tail_slot = '0;
		node_count = 0;
		free_slots = '1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_append_extremes();
		test_delete_cases();
		test_full_list();
		test_backpressure();
		test_steady_stream();
		test_random_traffic();

		wait_results_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
rtl/cle_pkg.sv
rtl/cle_node_mem.sv
rtl/circular_list_engine.sv
tb/tb_circular_list_engine.sv
